/* design/aes192_pkg.sv */
// Shared types, constants and round functions for the AES-192 cipher unit.
package aes192_pkg;

	localparam int unsigned RK_DEPTH = 13;
	localparam int unsigned RK_AW    = 4;

	localparam logic [4:0] KEXP_LAST = 5'd25;
	localparam logic [4:0] KEXP_KEYS = 5'd3;
	localparam logic [3:0] RND_LAST  = 4'd12;

	localparam logic [2:0] MODE_ECB  = 3'd0;
	localparam logic [2:0] MODE_CBC  = 3'd1;
	localparam logic [2:0] MODE_PCBC = 3'd2;
	localparam logic [2:0] MODE_CTR  = 3'd3;
	localparam logic [2:0] MODE_CFB  = 3'd4;

	localparam logic [2:0] REG_KEY_HIGH  = 3'd0;
	localparam logic [2:0] REG_KEY_MID   = 3'd1;
	localparam logic [2:0] REG_KEY_LOW   = 3'd2;
	localparam logic [2:0] REG_IV_HIGH   = 3'd3;
	localparam logic [2:0] REG_IV_LOW    = 3'd4;
	localparam logic [2:0] REG_MODE      = 3'd5;
	localparam logic [2:0] REG_DIRECTION = 3'd6;

	typedef struct packed {
		logic       capture;
		logic       key_wr;
		logic [4:0] key_idx;
		logic       load;
		logic       rnd;
		logic [3:0] rnd_idx;
		logic       finish;
	} aes192_cmd_t;

	typedef struct packed {
		logic key_changed;
	} aes192_status_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] sbox(input logic [7:0] x);
		return SBOX[x];
	endfunction

	// linear part of the inverse affine map
	function automatic logic [7:0] lin_inv(input logic [7:0] y);
		return {y[6:0], y[7]} ^ {y[4:0], y[7:5]} ^ {y[1:0], y[7:2]};
	endfunction

	// inverse S-box built from the forward table: A^-1(S(A^-1(y)))
	function automatic logic [7:0] inv_sbox(input logic [7:0] y);
		logic [7:0] z;
		z = lin_inv(y) ^ 8'h05;
		return lin_inv(sbox(z)) ^ 8'h05;
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_rot(input logic [31:0] w);
		logic [31:0] r;
		r = {w[23:0], w[31:24]};
		return {sbox(r[31:24]), sbox(r[23:16]), sbox(r[15:8]), sbox(r[7:0])};
	endfunction

	function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic [127:0] k,
			input logic last);
		logic [7:0]   t [16];
		logic [7:0]   o [16];
		logic [127:0] r;
		for (int c = 0; c < 4; c++) begin
			for (int q = 0; q < 4; q++) begin
				t[q + 4 * c] = sbox(s[127 - 8 * (q + 4 * ((c + q) & 3)) -: 8]);
			end
		end
		for (int c = 0; c < 4; c++) begin
			if (last) begin
				for (int q = 0; q < 4; q++) o[4 * c + q] = t[4 * c + q];
			end else begin
				o[4 * c]     = xt(t[4*c]) ^ xt(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
				o[4 * c + 1] = t[4*c] ^ xt(t[4*c+1]) ^ xt(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
				o[4 * c + 2] = t[4*c] ^ t[4*c+1] ^ xt(t[4*c+2]) ^ xt(t[4*c+3]) ^ t[4*c+3];
				o[4 * c + 3] = xt(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xt(t[4*c+3]);
			end
		end
		for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = o[i];
		return r ^ k;
	endfunction

	function automatic logic [127:0] inv_round(input logic [127:0] s, input logic [127:0] k,
			input logic last);
		logic [7:0]   t [16];
		logic [7:0]   a [16];
		logic [7:0]   x2, x4, x8;
		logic [7:0]   m9 [16];
		logic [7:0]   m11 [16];
		logic [7:0]   m13 [16];
		logic [7:0]   m14 [16];
		logic [127:0] r;
		for (int c = 0; c < 4; c++) begin
			for (int q = 0; q < 4; q++) begin
				t[q + 4 * ((c + q) & 3)] = inv_sbox(s[127 - 8 * (q + 4 * c) -: 8]);
			end
		end
		for (int i = 0; i < 16; i++) begin
			a[i]   = t[i] ^ k[127 - 8 * i -: 8];
			x2     = xt(a[i]);
			x4     = xt(x2);
			x8     = xt(x4);
			m9[i]  = x8 ^ a[i];
			m11[i] = x8 ^ x2 ^ a[i];
			m13[i] = x8 ^ x4 ^ a[i];
			m14[i] = x8 ^ x4 ^ x2;
		end
		for (int c = 0; c < 4; c++) begin
			if (last) begin
				for (int q = 0; q < 4; q++) r[127 - 8 * (4 * c + q) -: 8] = a[4 * c + q];
			end else begin
				r[127 - 8 * (4*c)   -: 8] = m14[4*c] ^ m11[4*c+1] ^ m13[4*c+2] ^ m9[4*c+3];
				r[127 - 8 * (4*c+1) -: 8] = m9[4*c] ^ m14[4*c+1] ^ m11[4*c+2] ^ m13[4*c+3];
				r[127 - 8 * (4*c+2) -: 8] = m13[4*c] ^ m9[4*c+1] ^ m14[4*c+2] ^ m11[4*c+3];
				r[127 - 8 * (4*c+3) -: 8] = m11[4*c] ^ m13[4*c+1] ^ m9[4*c+2] ^ m14[4*c+3];
			end
		end
		return r;
	endfunction

endpackage

/* design/aes192_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module aes192_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 13,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/aes192_dp.sv */
// Datapath: config registers, key schedule, round key RAMs, round unit and chaining.
module aes192_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic [2:0]                 cfg_index,
	input  logic [63:0]                cfg_data,
	input  logic [63:0]                block_high,
	input  logic [63:0]                block_low,
	input  logic                       first_block,
	input  aes192_pkg::aes192_cmd_t    cmd,
	output aes192_pkg::aes192_status_t status,
	output logic [63:0]                result_high,
	output logic [63:0]                result_low
);

	logic [63:0]  key_high_q, key_mid_q, key_low_q, iv_high_q, iv_low_q;
	logic [2:0]   mode_q;
	logic         dir_q;
	logic [127:0] data_q, chain_q, state_q, res_q;
	logic [63:0]  ctr_q;
	logic [191:0] win_q;
	logic [1:0]   phase_q;
	logic [7:0]   rc_q;

	logic         inv;
	logic [31:0]  t0, w6, w7;
	logic [63:0]  kwdata;
	logic [3:0]   step_nxt, raddr;
	logic [63:0]  rk_even, rk_odd;
	logic [127:0] rk, init_blk, post, res, round_out;
	logic [63:0]  ctr_bytes;

	// CTR and CFB always run the forward cipher
	assign inv = dir_q && (mode_q != aes192_pkg::MODE_CTR) && (mode_q != aes192_pkg::MODE_CFB);

	assign status.key_changed = cfg_valid && (cfg_index == aes192_pkg::REG_KEY_HIGH ||
		cfg_index == aes192_pkg::REG_KEY_MID || cfg_index == aes192_pkg::REG_KEY_LOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_mid_q  <= '0;
			key_low_q  <= '0;
			iv_high_q  <= '0;
			iv_low_q   <= '0;
			mode_q     <= aes192_pkg::MODE_ECB;
			dir_q      <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				aes192_pkg::REG_KEY_HIGH:  key_high_q <= cfg_data;
				aes192_pkg::REG_KEY_MID:   key_mid_q  <= cfg_data;
				aes192_pkg::REG_KEY_LOW:   key_low_q  <= cfg_data;
				aes192_pkg::REG_IV_HIGH:   iv_high_q  <= cfg_data;
				aes192_pkg::REG_IV_LOW:    iv_low_q   <= cfg_data;
				aes192_pkg::REG_MODE:      mode_q     <= cfg_data[2:0];
				aes192_pkg::REG_DIRECTION: dir_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// key schedule: two words per cycle from a six-word window
	assign t0 = (phase_q == 2'd0) ? (aes192_pkg::sub_rot(win_q[31:0]) ^ {rc_q, 24'h0})
		: win_q[31:0];
	assign w6 = win_q[191:160] ^ t0;
	assign w7 = win_q[159:128] ^ w6;

	always_comb begin
		unique case (cmd.key_idx)
			5'd0:    kwdata = key_high_q;
			5'd1:    kwdata = key_mid_q;
			5'd2:    kwdata = key_low_q;
			default: kwdata = {w6, w7};
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.key_wr) begin
			if (cmd.key_idx == 5'd2) begin
				win_q   <= {key_high_q, key_mid_q, key_low_q};
				phase_q <= 2'd0;
				rc_q    <= 8'h01;
			end else if (cmd.key_idx >= aes192_pkg::KEXP_KEYS) begin
				win_q   <= {win_q[127:0], w6, w7};
				phase_q <= (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
				if (phase_q == 2'd0) rc_q <= {rc_q[6:0], 1'b0};
			end
		end
	end

	// round key fetch one step ahead of the round unit
	always_comb begin
		if (cmd.load || cmd.rnd_idx == aes192_pkg::RND_LAST) step_nxt = 4'd0;
		else step_nxt = cmd.rnd_idx + 4'd1;
		raddr = inv ? (aes192_pkg::RND_LAST - step_nxt) : step_nxt;
	end

	aes192_ram #(.WIDTH(64), .DEPTH(aes192_pkg::RK_DEPTH), .AW(aes192_pkg::RK_AW)) u_rk_even (
		.clk   (clk),
		.we    (cmd.key_wr && !cmd.key_idx[0]),
		.waddr (cmd.key_idx[4:1]),
		.wdata (kwdata),
		.raddr (raddr),
		.rdata (rk_even)
	);

	aes192_ram #(.WIDTH(64), .DEPTH(aes192_pkg::RK_DEPTH), .AW(aes192_pkg::RK_AW)) u_rk_odd (
		.clk   (clk),
		.we    (cmd.key_wr && cmd.key_idx[0]),
		.waddr (cmd.key_idx[4:1]),
		.wdata (kwdata),
		.raddr (raddr),
		.rdata (rk_odd)
	);

	assign rk = {rk_even, rk_odd};

	// counter goes in least significant byte first
	always_comb begin
		for (int i = 0; i < 8; i++) ctr_bytes[63 - 8 * i -: 8] = ctr_q[8 * i +: 8];
	end

	always_comb begin
		unique case (mode_q)
			aes192_pkg::MODE_CBC, aes192_pkg::MODE_PCBC: begin
				init_blk = inv ? data_q : (data_q ^ chain_q);
				post     = inv ? chain_q : '0;
			end
			aes192_pkg::MODE_CTR: begin
				init_blk = {iv_high_q, ctr_bytes};
				post     = data_q;
			end
			aes192_pkg::MODE_CFB: begin
				init_blk = chain_q;
				post     = data_q;
			end
			default: begin
				init_blk = data_q;
				post     = '0;
			end
		endcase
	end

	assign round_out = inv
		? aes192_pkg::inv_round(state_q, rk, cmd.rnd_idx == aes192_pkg::RND_LAST)
		: aes192_pkg::fwd_round(state_q, rk, cmd.rnd_idx == aes192_pkg::RND_LAST);
	assign res = state_q ^ post;

	always_ff @(posedge clk) begin
		if (cmd.capture) data_q <= {block_high, block_low};
		if (cmd.rnd) state_q <= (cmd.rnd_idx == 4'd0) ? (init_blk ^ rk) : round_out;
		if (cmd.finish) res_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
			ctr_q   <= '0;
		end else if (cmd.capture) begin
			if (first_block) begin
				chain_q <= {iv_high_q, iv_low_q};
				ctr_q   <= '0;
			end
		end else if (cmd.finish) begin
			unique case (mode_q)
				aes192_pkg::MODE_CBC:  chain_q <= inv ? data_q : res;
				aes192_pkg::MODE_PCBC: chain_q <= data_q ^ res;
				aes192_pkg::MODE_CFB:  chain_q <= dir_q ? data_q : res;
				aes192_pkg::MODE_CTR:  ctr_q   <= ctr_q + 64'd1;
				default: ;
			endcase
		end
	end

	assign result_high = res_q[127:64];
	assign result_low  = res_q[63:0];

endmodule

/* design/aes192_ctrl.sv */
// Controller: sequences key expansion, rounds and the result handshake.
module aes192_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       blk_valid,
	output logic                       blk_ready,
	output logic                       res_valid,
	input  logic                       res_ready,
	input  aes192_pkg::aes192_status_t status,
	output aes192_pkg::aes192_cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_KEXP  = 5'b00010,
		ST_LOAD  = 5'b00100,
		ST_ROUND = 5'b01000,
		ST_DONE  = 5'b10000
	} aes192_state_t;

	aes192_state_t state_q, state_nxt;
	logic [4:0]    cnt_q;
	logic          keys_valid_q;
	logic          res_valid_q;

	always_comb begin
		cmd       = '0;
		blk_ready = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				blk_ready = 1'b1;
				if (blk_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = keys_valid_q ? ST_LOAD : ST_KEXP;
				end
			end
			ST_KEXP: begin
				cmd.key_wr  = 1'b1;
				cmd.key_idx = cnt_q;
				if (cnt_q == aes192_pkg::KEXP_LAST) state_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load  = 1'b1;
				state_nxt = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.rnd     = 1'b1;
				cmd.rnd_idx = cnt_q[3:0];
				if (cnt_q[3:0] == aes192_pkg::RND_LAST) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!res_valid_q || res_ready) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			keys_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q != state_nxt) cnt_q <= '0;
			else cnt_q <= cnt_q + 5'd1;
			if (status.key_changed) keys_valid_q <= 1'b0;
			else if (cmd.key_wr && cnt_q == aes192_pkg::KEXP_LAST) keys_valid_q <= 1'b1;
			if (cmd.finish) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;

`ifndef NO_ASSERTIONS
	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> res_valid_q) else $error("result not presented after finish");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_ready) |-> !cmd.finish) else $error("waiting result overwritten");
	a_keys_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rnd |-> keys_valid_q) else $error("round run with stale keys");
	a_kexp_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.key_wr |-> cnt_q <= aes192_pkg::KEXP_LAST) else $error("key index overrun");
	a_capture_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_LOAD || state_q == ST_KEXP))
		else $error("capture not followed by work");
`endif

endmodule

/* design/aes192_block_cipher_modes_unit.sv */
// Top level of the AES-192 unit with ECB, CBC, PCBC, CTR and CFB chaining.
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes key, IV, mode and
//    direction; cfg_ready is always high and writes belong to idle periods only.
//    Writing any key word forces a fresh key expansion on the next block.
//  - blk channel takes one 128-bit block per transaction (block_high, block_low,
//    first_block); first_block reloads the chain from the IV and zeroes the counter.
//  - res channel returns one 128-bit result per block (result_high, result_low).
// Timing: a block passes a fetch step (ST_LOAD), the rounds through the single round
//  unit (ST_ROUND) and a hand-off step (ST_DONE); a new block is taken only after the
//  last has been handed off, so the round loop is what limits the block rate.
//  After a key change the key schedule first refills the round key RAMs, one 64-bit entry per cycle.
// The result register decouples the sides: a block is accepted while the previous
//  result still waits; if the receiver stalls, the finished block holds in the
//  round unit until the result register frees up.
// Reset clears config, chain value, counter and the keys-valid flag; no items in flight.
module aes192_block_cipher_modes_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        blk_valid,
	output logic        blk_ready,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	input  logic        first_block,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);

	aes192_pkg::aes192_cmd_t    cmd;
	aes192_pkg::aes192_status_t status;

	// register writes never stall
	assign cfg_ready = 1'b1;

	aes192_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_valid (blk_valid),
		.blk_ready (blk_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.status    (status),
		.cmd       (cmd)
	);

	aes192_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.block_high  (block_high),
		.block_low   (block_low),
		.first_block (first_block),
		.cmd         (cmd),
		.status      (status),
		.result_high (result_high),
		.result_low  (result_low)
	);

endmodule
